[hw/rtl/ceab_pkg.sv]
// Package for the compatibility EM abundance unit.
// Widths, codes, controller states and the controller/datapath command types.
// No dependencies.
package ceab_pkg;

	// Field and arithmetic widths
	localparam int MASK_W   = 32;
	localparam int CNT_W    = 16;
	localparam int AB_W     = 33;
	localparam int RSUM_W   = 38;
	localparam int PROD_W   = 49;
	localparam int SQ_W     = 66;
	localparam int SSQ_W    = 71;
	localparam int TSQ_W    = 64;
	localparam int LIM_W    = 70;
	localparam int ITER_W   = 16;
	localparam int NCFG_W   = 6;
	localparam int TOL_W    = 32;
	localparam int CIDX_W   = 5;
	localparam int ST_W     = 2;
	localparam int REG_IDX_W = 2;
	localparam int SHARE_STEPS = 32;

	localparam logic [AB_W-1:0] ONE_Q32 = {1'b1, 32'h0};

	// Defaults for the top-level parameters
	localparam int MAX_CAT_DEF = 32;
	localparam int MAX_PAT_DEF = 1024;

	// Register reset values
	localparam logic [NCFG_W-1:0] NCAT_RST  = 6'd32;
	localparam logic [ITER_W-1:0] MAXIT_RST = 16'd1000;
	localparam logic [TOL_W-1:0]  TOL_RST   = 32'd42950;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_NCAT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAXIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_TOL   = 2'd2;

	// Run status codes
	localparam logic [ST_W-1:0] ST_CONV  = 2'd0;
	localparam logic [ST_W-1:0] ST_LIMIT = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO  = 2'd2;
	localparam logic [ST_W-1:0] ST_DROP  = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_RUN, S_INIT_WAIT, S_INIT_WR, S_CHECK, S_ACC_CLR, S_PAT_CHK,
		S_RSUM, S_SH_TEST, S_SH_CHK, S_SH_WAIT, S_MUL, S_ACC, S_UPD_DIV,
		S_UPD_WAIT, S_UPD_SQ, S_UPD_ACC, S_CONV, S_EMIT_LD, S_EMIT_WT
	} ceab_state_t;

	typedef enum logic [1:0] {DIV_INIT, DIV_SHARE, DIV_EXP} ceab_div_sel_t;

	typedef enum logic [1:0] {J_HOLD, J_INC, J_CLR} ceab_jop_t;

	typedef struct packed {
		logic          pat_ready;
		logic          run_start;
		logic          div_start;
		ceab_div_sel_t div_sel;
		ceab_jop_t     j_op;
		logic          init_wr;
		logic          lim_ld;
		logic          acc_clr;
		logic          i_clr;
		logic          i_inc;
		logic          pat_rd;
		logic          rsum_clr;
		logic          rsum_add;
		logic          share_ld;
		logic          mul;
		logic          acc_add;
		logic          upd_sq;
		logic          ssq_clr;
		logic          ssq_add;
		logic          iter_inc;
		logic          emit_ld;
		logic          batch_clr;
	} ceab_cmd_t;

	typedef struct packed {
		logic last_acc;
		logic j_end;
		logic i_end;
		logic bit_set;
		logic rsum_zero;
		logic part_ge;
		logic div_busy;
		logic total_zero;
		logic maxit_hit;
		logic conv;
		logic res_taken;
	} ceab_sts_t;

endpackage

[hw/rtl/ceab_ifs.sv]
// Channel interfaces of the compatibility EM abundance unit: patterns in,
// abundances out, register writes. Depends on ceab_pkg.
interface ceab_pat_if import ceab_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] compat_mask;
	logic [CNT_W-1:0]  read_count;
	logic              last_pattern;
	modport source(output valid, compat_mask, read_count, last_pattern, input ready);
	modport sink(input valid, compat_mask, read_count, last_pattern, output ready);
endinterface

interface ceab_res_if import ceab_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] category_index;
	logic [AB_W-1:0]   abundance;
	logic [ITER_W-1:0] iterations_run;
	logic [ST_W-1:0]   run_status;
	logic              last_result;
	modport source(output valid, category_index, abundance, iterations_run, run_status,
		last_result, input ready);
	modport sink(input valid, category_index, abundance, iterations_run, run_status,
		last_result, output ready);
endinterface

interface ceab_cfg_if import ceab_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [TOL_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/ceab_div.sv]
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// Depends on ceab_pkg.
module ceab_div import ceab_pkg::*; #(
	parameter int NW = 60,
	localparam int SW = $clog2(NW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RSUM_W-1:0] rem_init,
	input  logic [NW-1:0]     num,
	input  logic [RSUM_W-1:0] den,
	input  logic [SW-1:0]     steps,
	output logic              busy,
	output logic [NW-1:0]     quo
);
	logic [RSUM_W-1:0] rem_q, den_q;
	logic [NW-1:0]     sh_q, quo_q;
	logic [SW-1:0]     cnt_q;
	logic              busy_q;
	logic [RSUM_W:0]   trial, diff;
	logic              ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, sh_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == SW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= den;
			sh_q  <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RSUM_W-1:0] : trial[RSUM_W-1:0];
			sh_q  <= {sh_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

[hw/rtl/ceab_ctrl.sv]
// Sequencer of the abundance unit: loading, EM iterations, result emission.
// Depends on ceab_pkg; drives ceab_dp through ceab_cmd_t.
module ceab_ctrl import ceab_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ceab_sts_t sts,
	output ceab_cmd_t cmd
);
	ceab_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (sts.last_acc) state_d = S_RUN;
			S_RUN:       state_d = S_INIT_WAIT;
			S_INIT_WAIT: if (!sts.div_busy) state_d = S_INIT_WR;
			S_INIT_WR:   if (sts.j_end) state_d = S_CHECK;
			S_CHECK: begin
				if (sts.total_zero || sts.conv || sts.maxit_hit) state_d = S_EMIT_LD;
				else                                             state_d = S_ACC_CLR;
			end
			S_ACC_CLR:   if (sts.j_end) state_d = S_PAT_CHK;
			S_PAT_CHK:   state_d = sts.i_end ? S_UPD_DIV : S_RSUM;
			S_RSUM:      if (sts.j_end) state_d = S_SH_TEST;
			S_SH_TEST:   state_d = sts.rsum_zero ? S_PAT_CHK : S_SH_CHK;
			S_SH_CHK: begin
				if (!sts.bit_set) begin
					if (sts.j_end) state_d = S_PAT_CHK;
				end else if (sts.part_ge) begin
					state_d = S_MUL;
				end else begin
					state_d = S_SH_WAIT;
				end
			end
			S_SH_WAIT:   if (!sts.div_busy) state_d = S_MUL;
			S_MUL:       state_d = S_ACC;
			S_ACC:       state_d = sts.j_end ? S_PAT_CHK : S_SH_CHK;
			S_UPD_DIV:   state_d = S_UPD_WAIT;
			S_UPD_WAIT:  if (!sts.div_busy) state_d = S_UPD_SQ;
			S_UPD_SQ:    state_d = S_UPD_ACC;
			S_UPD_ACC:   state_d = sts.j_end ? S_CONV : S_UPD_DIV;
			S_CONV:      state_d = S_CHECK;
			S_EMIT_LD:   state_d = S_EMIT_WT;
			S_EMIT_WT: begin
				if (sts.res_taken) state_d = sts.j_end ? S_IDLE : S_EMIT_LD;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.j_op    = J_HOLD;
		cmd.div_sel = DIV_INIT;
		case (state_q)
			S_IDLE: cmd.pat_ready = 1'b1;
			S_RUN: begin
				cmd.run_start = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INIT;
				cmd.j_op      = J_CLR;
			end
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				cmd.lim_ld  = 1'b1;
				cmd.j_op    = sts.j_end ? J_HOLD : J_INC;
			end
			S_CHECK: begin
				cmd.j_op    = J_CLR;
				cmd.i_clr   = 1'b1;
				cmd.ssq_clr = 1'b1;
			end
			S_ACC_CLR: begin
				cmd.acc_clr = 1'b1;
				cmd.j_op    = sts.j_end ? J_HOLD : J_INC;
			end
			S_PAT_CHK: begin
				cmd.j_op     = J_CLR;
				cmd.pat_rd   = !sts.i_end;
				cmd.rsum_clr = !sts.i_end;
			end
			S_RSUM: begin
				cmd.rsum_add = 1'b1;
				cmd.j_op     = sts.j_end ? J_CLR : J_INC;
			end
			S_SH_TEST: cmd.i_inc = sts.rsum_zero;
			S_SH_CHK: begin
				if (!sts.bit_set) begin
					if (sts.j_end) cmd.i_inc = 1'b1;
					else           cmd.j_op  = J_INC;
				end else if (sts.part_ge) begin
					cmd.share_ld = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SHARE;
				end
			end
			S_SH_WAIT: cmd.share_ld = !sts.div_busy;
			S_MUL:     cmd.mul = 1'b1;
			S_ACC: begin
				cmd.acc_add = 1'b1;
				if (sts.j_end) cmd.i_inc = 1'b1;
				else           cmd.j_op  = J_INC;
			end
			S_UPD_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_EXP;
			end
			S_UPD_SQ: cmd.upd_sq = 1'b1;
			S_UPD_ACC: begin
				cmd.ssq_add = 1'b1;
				cmd.j_op    = sts.j_end ? J_HOLD : J_INC;
			end
			S_CONV:    cmd.iter_inc = 1'b1;
			S_EMIT_LD: cmd.emit_ld = 1'b1;
			S_EMIT_WT: begin
				if (sts.res_taken) begin
					if (sts.j_end) cmd.batch_clr = 1'b1;
					else           cmd.j_op      = J_INC;
				end
			end
			default: cmd.j_op = J_HOLD;
		endcase
	end
endmodule

[hw/rtl/ceab_dp.sv]
// Datapath of the abundance unit: pattern memories, abundance and expected
// count arrays, divider, multipliers, registers and output register.
// Depends on ceab_pkg, ceab_ifs, ceab_div.
module ceab_dp import ceab_pkg::*; #(
	parameter int MAX_CATEGORIES = MAX_CAT_DEF,
	parameter int MAX_PATTERNS   = MAX_PAT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ceab_cmd_t  cmd,
	output ceab_sts_t  sts,
	ceab_pat_if.sink   pat,
	ceab_res_if.source res,
	ceab_cfg_if.sink   cfg
);
	localparam int NCAT = (MAX_CATEGORIES < MASK_W) ? MAX_CATEGORIES : MASK_W;
	localparam int JW   = (NCAT > 1) ? $clog2(NCAT) : 1;
	localparam int PW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int FW   = $clog2(MAX_PATTERNS + 1);
	localparam int TW   = CNT_W + FW;
	localparam int AW   = PROD_W + FW;
	localparam int SW   = $clog2(AW + 1);

	// configuration registers
	logic [NCFG_W-1:0] ncat_q;
	logic [ITER_W-1:0] maxit_q;
	logic [TOL_W-1:0]  tol_q;

	// batch and loop control
	logic [FW-1:0]     fill_q, i_q;
	logic [TW-1:0]     total_q;
	logic              ovf_q, conv_q;
	logic [NCFG_W-1:0] n_q, n_act;
	logic [JW-1:0]     j_q;
	logic [ITER_W-1:0] iter_q;

	// payload
	logic [MASK_W-1:0] mask_mem [MAX_PATTERNS];
	logic [CNT_W-1:0]  cnt_mem  [MAX_PATTERNS];
	logic [MASK_W-1:0] rd_mask_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic [AB_W-1:0]   old_q [NCAT];
	logic [AW-1:0]     acc_q [NCAT];
	logic [RSUM_W-1:0] rsum_q;
	logic [AB_W-1:0]   share_q;
	logic [PROD_W-1:0] prod_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic [SSQ_W-1:0]  ssq_q;
	logic [TSQ_W-1:0]  tsq_q;
	logic [LIM_W-1:0]  lim_q;

	// output register
	logic              res_valid_q, res_last_q;
	logic [CIDX_W-1:0] res_idx_q;
	logic [AB_W-1:0]   res_ab_q;
	logic [ITER_W-1:0] res_iter_q;
	logic [ST_W-1:0]   res_st_q;

	// divider hookup
	logic              div_busy;
	logic [AW-1:0]     div_quo, div_num;
	logic [RSUM_W-1:0] div_rem, div_den;
	logic [SW-1:0]     div_steps;

	logic              pat_acc, full, res_taken;
	logic [AB_W-1:0]   old_j, v_sat, d_abs;
	logic [ST_W-1:0]   run_st;

	assign pat_acc   = pat.valid && cmd.pat_ready;
	assign res_taken = res_valid_q && res.ready;
	assign full      = (fill_q == FW'(MAX_PATTERNS));
	assign old_j     = old_q[j_q];

	// active category count
	always_comb begin
		n_act = ncat_q;
		if (n_act == '0) n_act = NCFG_W'(MASK_W);
		if (n_act > NCFG_W'(NCAT)) n_act = NCFG_W'(NCAT);
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_SHARE: begin
				div_rem   = RSUM_W'(old_j);
				div_num   = '0;
				div_den   = rsum_q;
				div_steps = SW'(SHARE_STEPS);
			end
			DIV_EXP: begin
				div_rem   = '0;
				div_num   = acc_q[j_q];
				div_den   = RSUM_W'(total_q);
				div_steps = SW'(AW);
			end
			default: begin
				div_rem   = '0;
				div_num   = AW'(ONE_Q32);
				div_den   = RSUM_W'(n_act);
				div_steps = SW'(AW);
			end
		endcase
	end

	ceab_div #(.NW(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem),
		.num      (div_num),
		.den      (div_den),
		.steps    (div_steps),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	// new abundance, saturated, and its change
	always_comb begin
		v_sat = (div_quo > AW'(ONE_Q32)) ? ONE_Q32 : div_quo[AB_W-1:0];
		d_abs = (v_sat > old_j) ? v_sat - old_j : old_j - v_sat;
	end

	always_comb begin
		if (total_q == '0)  run_st = ST_ZERO;
		else if (ovf_q)     run_st = ST_DROP;
		else if (conv_q)    run_st = ST_CONV;
		else                run_st = ST_LIMIT;
	end

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncat_q  <= NCAT_RST;
			maxit_q <= MAXIT_RST;
			tol_q   <= TOL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NCAT:  ncat_q  <= cfg.data[NCFG_W-1:0];
				REG_MAXIT: maxit_q <= cfg.data[ITER_W-1:0];
				REG_TOL:   tol_q   <= cfg.data;
				default:   ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			conv_q      <= 1'b0;
			n_q         <= NCAT_RST;
			i_q         <= '0;
			j_q         <= '0;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pat_acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q  <= fill_q + 1'b1;
					total_q <= total_q + TW'(pat.read_count);
				end
			end
			if (cmd.batch_clr) begin
				fill_q  <= '0;
				total_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.run_start) begin
				n_q    <= n_act;
				iter_q <= '0;
				conv_q <= 1'b0;
			end
			if (cmd.iter_inc) begin
				iter_q <= iter_q + 1'b1;
				conv_q <= (ssq_q <= SSQ_W'(lim_q));
			end
			if (cmd.i_clr)      i_q <= '0;
			else if (cmd.i_inc) i_q <= i_q + 1'b1;
			case (cmd.j_op)
				J_INC:   j_q <= j_q + 1'b1;
				J_CLR:   j_q <= '0;
				default: j_q <= j_q;
			endcase
			if (cmd.emit_ld)  res_valid_q <= 1'b1;
			else if (res_taken) res_valid_q <= 1'b0;
		end
	end

	// pattern memories
	always_ff @(posedge clk) begin
		if (pat_acc && !full) begin
			mask_mem[fill_q[PW-1:0]] <= pat.compat_mask;
			cnt_mem[fill_q[PW-1:0]]  <= pat.read_count;
		end
		if (cmd.pat_rd) begin
			rd_mask_q <= mask_mem[i_q[PW-1:0]];
			rd_cnt_q  <= cnt_mem[i_q[PW-1:0]];
		end
	end

	// abundance and accumulator arrays, arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.init_wr)     old_q[j_q] <= div_quo[AB_W-1:0];
		else if (cmd.upd_sq) old_q[j_q] <= v_sat;
		if (cmd.acc_clr)      acc_q[j_q] <= '0;
		else if (cmd.acc_add) acc_q[j_q] <= acc_q[j_q] + AW'(prod_s1);
		if (cmd.rsum_clr)
			rsum_q <= '0;
		else if (cmd.rsum_add && rd_mask_q[j_q])
			rsum_q <= rsum_q + RSUM_W'(old_j);
		if (cmd.share_ld)
			share_q <= (RSUM_W'(old_j) >= rsum_q) ? ONE_Q32 : div_quo[AB_W-1:0];
		if (cmd.mul)       prod_s1 <= PROD_W'(share_q) * PROD_W'(rd_cnt_q);
		if (cmd.upd_sq)    sq_s1 <= SQ_W'(d_abs) * SQ_W'(d_abs);
		if (cmd.ssq_clr)      ssq_q <= '0;
		else if (cmd.ssq_add) ssq_q <= ssq_q + SSQ_W'(sq_s1);
		if (cmd.run_start) tsq_q <= TSQ_W'(tol_q) * TSQ_W'(tol_q);
		if (cmd.lim_ld)    lim_q <= LIM_W'(tsq_q) * LIM_W'(n_q);
		if (cmd.emit_ld) begin
			res_idx_q  <= CIDX_W'(j_q);
			res_ab_q   <= old_j;
			res_iter_q <= iter_q;
			res_st_q   <= run_st;
			res_last_q <= (NCFG_W'(j_q) == n_q - 1'b1);
		end
	end

	assign pat.ready          = cmd.pat_ready;
	assign res.valid          = res_valid_q;
	assign res.category_index = res_idx_q;
	assign res.abundance      = res_ab_q;
	assign res.iterations_run = res_iter_q;
	assign res.run_status     = res_st_q;
	assign res.last_result    = res_last_q;

	// status to the sequencer
	always_comb begin
		sts.last_acc   = pat_acc && pat.last_pattern;
		sts.j_end      = (NCFG_W'(j_q) == n_q - 1'b1);
		sts.i_end      = (i_q == fill_q);
		sts.bit_set    = rd_mask_q[j_q];
		sts.rsum_zero  = (rsum_q == '0);
		sts.part_ge    = (RSUM_W'(old_j) >= rsum_q);
		sts.div_busy   = div_busy;
		sts.total_zero = (total_q == '0);
		sts.maxit_hit  = (iter_q == maxit_q);
		sts.conv       = conv_q;
		sts.res_taken  = res_taken;
	end
endmodule

[hw/rtl/compatibility_em_abundance_unit.sv]
// Compatibility EM abundance unit, top level.
// Channels: pat (compatibility patterns in), res (abundances out), cfg (register
// writes: 0 category count, 1 iteration limit, 2 tolerance; always ready).
// Each pattern transaction is taken in one cycle while the unit is loading. The
// transaction marked last_pattern starts the EM run; pat.ready stays low until
// every result of that run has been delivered.
// Run: the divider first seeds every abundance with 1.0/n (an AW-step division,
// AW = accumulator width, 60 at the default size). Each iteration then clears
// the accumulators, reads the stored patterns and, for each pattern with a
// nonzero row sum, adds share * read count for every compatible category, the
// share being 1.0 or a 32-step division; each accumulator divided by the total
// read count gives the new abundance. One shared bit-serial divider does all three.
// Results: n transactions, one per category, each loaded after the previous is taken; a stalled
// receiver holds the output register and the unit waits.
// Reset clears the registers to their defaults and empties the pattern batch.
// Depends on ceab_pkg, ceab_ifs, ceab_ctrl, ceab_dp.
module compatibility_em_abundance_unit import ceab_pkg::*; #(
	parameter int MAX_CATEGORIES = MAX_CAT_DEF,
	parameter int MAX_PATTERNS   = MAX_PAT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ceab_pat_if.sink   pat,
	ceab_res_if.source res,
	ceab_cfg_if.sink   cfg
);
	ceab_cmd_t cmd;
	ceab_sts_t sts;

	ceab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ceab_dp #(
		.MAX_CATEGORIES (MAX_CATEGORIES),
		.MAX_PATTERNS   (MAX_PATTERNS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.pat    (pat),
		.res    (res),
		.cfg    (cfg)
	);
endmodule
